FILE: rtl/ptts_pkg.sv
// ---------------------------------------------------------------------------
// Periodic task tick scheduler package
// Command and status codes and the fixed field widths of the scheduler ports.
// ---------------------------------------------------------------------------
package ptts_pkg;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 6;
    localparam int TIME_W = 16;
    localparam int CFG_W  = 16;
    localparam int MASK_W = 64;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: rtl/ptts_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module ptts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/periodic_task_tick_scheduler_top.sv
// ---------------------------------------------------------------------------
// Periodic task tick scheduler
// A table of periodic task slots; commands create, suspend, resume or delete
// a slot, and a tick counts every running slot down and reports which fired.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall i_command, i_task_id,
//                                              i_first_delay, i_period
// result    out        o_out_valid / i_out_stall o_fired_mask, o_status
// config    in         i_cfg_we                i_cfg_data (tick step)
//
// A tick walks the slot RAM one slot per cycle: the read of slot k is issued
// while slot k-1 is written back, and the tick ends once the last slot has
// been written back; its result is then placed in the holding register.
// Create, suspend, resume and delete finish in the cycle they are accepted
// and their result is registered in the holding register.
// Reset (synchronous, active low) clears the present and ready flags, the
// output register and the tick step (back to one). The RAM is not cleared:
// a slot's delay and period are only used while it is present.
// One word is worked on at a time; a finished result waits in a holding
// register while the output register is stalled, and the input is stalled
// until that holding register has moved on.
// ---------------------------------------------------------------------------
module periodic_task_tick_scheduler_top
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    parameter int TIME_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [ID_W-1:0]   i_task_id,
    input  logic [TIME_W-1:0] i_first_delay,
    input  logic [TIME_W-1:0] i_period,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_fired_mask,
    output logic [STAT_W-1:0] o_status,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int RW = 2 * TIME_WIDTH;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TICK = 1'b1;

    // Control state.
    logic               r_state;
    logic               r_present [TASK_SLOTS];
    logic               r_ready   [TASK_SLOTS];
    logic [CFG_W-1:0]   r_tick_step;
    logic               r_rd_on;
    logic [IW-1:0]      r_rd_idx;
    logic               r_wb_valid;
    logic [IW-1:0]      r_wb_idx;
    logic [MASK_W-1:0]  r_mask;
    logic               r_pend;
    logic [MASK_W-1:0]  r_pend_mask;
    logic [STAT_W-1:0]  r_pend_status;
    logic               r_out_valid;
    logic [MASK_W-1:0]  r_out_mask;
    logic [STAT_W-1:0]  r_out_status;

    logic                  accept;
    logic                  id_ok;
    logic [IW-1:0]         id_idx;
    logic [STAT_W-1:0]     cmd_status;
    logic [TIME_WIDTH-1:0] step;
    logic [RW-1:0]         ram_rdata;
    logic [RW-1:0]         ram_wdata;
    logic [IW-1:0]         ram_waddr;
    logic [IW-1:0]         ram_raddr;
    logic                  ram_we;
    logic [TIME_WIDTH-1:0] rd_delay;
    logic [TIME_WIDTH-1:0] rd_period;
    logic                  wb_live;
    logic                  wb_fire;
    logic [TIME_WIDTH-1:0] n_delay;
    logic [MASK_W-1:0]     n_mask;
    logic                  out_free;

    // Handshakes.
    assign o_in_stall = !((r_state == S_IDLE) && !r_pend);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign id_ok  = ({1'b0, i_task_id} < (ID_W + 1)'(TASK_SLOTS));
    assign id_idx = IW'(i_task_id);
    assign step   = TIME_WIDTH'(r_tick_step);

    // Status of a non-tick command, worked out in the cycle it is accepted.
    always_comb begin
        cmd_status = ST_OK;
        case (i_command)
            CMD_TICK: begin
                cmd_status = ST_OK;
            end
            CMD_CREATE: begin
                cmd_status = id_ok ? ST_OK : ST_RANGE;
            end
            CMD_SUSPEND, CMD_RESUME, CMD_DELETE: begin
                if (!id_ok) begin
                    cmd_status = ST_RANGE;
                end else if (!r_present[id_idx]) begin
                    cmd_status = ST_EMPTY;
                end
            end
            default: begin
                cmd_status = ST_OK;
            end
        endcase
    end

    // Write-back side of the tick sweep: the delay either reloads from the
    // period or counts down, and both subtractions stop at zero.
    assign rd_delay  = ram_rdata[TIME_WIDTH-1:0];
    assign rd_period = ram_rdata[RW-1:TIME_WIDTH];
    assign wb_live   = r_wb_valid && r_present[r_wb_idx] && r_ready[r_wb_idx];
    assign wb_fire   = wb_live && (rd_delay == '0);

    always_comb begin
        if (rd_delay == '0) begin
            n_delay = (rd_period > step) ? (rd_period - step) : '0;
        end else begin
            n_delay = (rd_delay > step) ? (rd_delay - step) : '0;
        end
        n_mask = r_mask;
        if (wb_fire) begin
            n_mask = r_mask | (MASK_W'(1) << r_wb_idx);
        end
    end

    // Create and the tick write-back never fall in the same cycle.
    always_comb begin
        if (r_wb_valid) begin
            ram_we    = wb_live;
            ram_waddr = r_wb_idx;
            ram_wdata = {rd_period, n_delay};
        end else begin
            ram_we    = accept && (i_command == CMD_CREATE) && id_ok;
            ram_waddr = id_idx;
            ram_wdata = {TIME_WIDTH'(i_period), TIME_WIDTH'(i_first_delay)};
        end
        ram_raddr = (r_state == S_TICK) ? r_rd_idx : '0;
    end

    ptts_ram #(
        .WIDTH (RW),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Slot flags, tick step and the sweep sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick_step <= CFG_W'(1);
            r_rd_on     <= 1'b0;
            r_rd_idx    <= '0;
            r_wb_valid  <= 1'b0;
            r_wb_idx    <= '0;
            r_mask      <= '0;
            r_pend      <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_present[i] <= 1'b0;
                r_ready[i]   <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tick_step <= i_cfg_data;
            end

            if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_command == CMD_TICK) begin
                            r_state    <= S_TICK;
                            r_rd_on    <= 1'b1;
                            r_rd_idx   <= '0;
                            r_wb_valid <= 1'b0;
                            r_mask     <= '0;
                        end else begin
                            r_pend        <= 1'b1;
                            r_pend_mask   <= '0;
                            r_pend_status <= cmd_status;
                            if (id_ok && (cmd_status == ST_OK)) begin
                                case (i_command)
                                    CMD_CREATE: begin
                                        r_present[id_idx] <= 1'b1;
                                        r_ready[id_idx]   <= 1'b1;
                                    end
                                    CMD_SUSPEND: begin
                                        r_ready[id_idx] <= 1'b0;
                                    end
                                    CMD_RESUME: begin
                                        r_ready[id_idx] <= 1'b1;
                                    end
                                    CMD_DELETE: begin
                                        r_present[id_idx] <= 1'b0;
                                        r_ready[id_idx]   <= 1'b0;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                end
                S_TICK: begin
                    r_wb_valid <= r_rd_on;
                    r_wb_idx   <= r_rd_idx;
                    r_mask     <= n_mask;
                    if (r_rd_on) begin
                        if (r_rd_idx == IW'(TASK_SLOTS - 1)) begin
                            r_rd_on <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + IW'(1);
                        end
                    end else if (r_wb_valid) begin
                        // Last slot written back: the tick result is complete.
                        r_state       <= S_IDLE;
                        r_wb_valid    <= 1'b0;
                        r_pend        <= 1'b1;
                        r_pend_mask   <= n_mask;
                        r_pend_status <= ST_OK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out_mask   <= r_pend_mask;
            r_out_status <= r_pend_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fired_mask = r_out_mask;
    assign o_status     = r_out_status;

endmodule

FILE: rtl/ptts_checker.sv
// ---------------------------------------------------------------------------
// Periodic task tick scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
module ptts_checker
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [MASK_W-1:0] o_fired_mask,
    input logic [STAT_W-1:0] o_status
);

    // A stalled result word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_fired_mask)
            && $stable(o_status))
        else $error("result word changed while stalled");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Only existing slots can fire.
    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fired_mask >> TASK_SLOTS) == '0)
        else $error("fired bit beyond the last slot");

    // Status is a known code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_RANGE
            || o_status == ST_EMPTY))
        else $error("unknown status code");

    // A rejected command never reports fired slots.
    a_err_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_fired_mask == '0)
        else $error("fired slots on a rejected command");

endmodule

bind periodic_task_tick_scheduler_top ptts_checker #(
    .TASK_SLOTS (TASK_SLOTS)
) u_ptts_checker (.*);
